FILE: src/sliding_window_rate_meter_unit_assert.svh
// assertion macros for the rate meter checker
`ifndef SLIDING_WINDOW_RATE_METER_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_RATE_METER_UNIT_ASSERT_SVH

// implication checked every clock unless in reset
`define SWRM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication with the consequent checked in the next cycle
`define SWRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/swrm_pkg.sv
`timescale 1ns / 1ps
package swrm_pkg;
   localparam int MaxBuckets = 1024;
   localparam int IdxW = $clog2(MaxBuckets);
   localparam int FillW = $clog2(MaxBuckets + 1);
   localparam int TimeW = 48;
   localparam int SumW = 64;
   localparam int SampW = 32;
   localparam int WinW = 11;
   localparam int ScaleW = 16;
   localparam int MemW = TimeW + SumW + SampW;
   localparam int AddrW = 1;

   localparam logic [AddrW-1:0] RegMaxWin = 1'd0;
   localparam logic [AddrW-1:0] RegScale = 1'd1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_QUERY = 2'd1,
      OP_SETWIN = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETWIN,
      ST_DROP_RD,
      ST_DROP_CHK,
      ST_ADD_START,
      ST_ADD_NEW_RD,
      ST_ADD_NEW_CHK,
      ST_ADD_WR,
      ST_Q_PREP,
      ST_Q_MUL,
      ST_Q_DIV,
      ST_Q_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic [SumW+SampW-1:0] dividend_hi;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;
endpackage

FILE: src/swrm_if.sv
`timescale 1ns / 1ps
interface swrm_req_if;
   import swrm_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] opcode;
   logic [31:0] count;
   logic [47:0] now_ms;
   logic [10:0] window_ms;
   modport source (output valid, opcode, count, now_ms, window_ms, input ready);
   modport sink (input valid, opcode, count, now_ms, window_ms, output ready);
endinterface

interface swrm_rsp_if;
   logic valid;
   logic ready;
   logic rate_valid;
   logic [62:0] rate_value;
   logic set_accepted;
   modport source (output valid, rate_valid, rate_value, set_accepted, input ready);
   modport sink (input valid, rate_valid, rate_value, set_accepted, output ready);
endinterface

FILE: src/swrm_ram.sv
`timescale 1ns / 1ps
module swrm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/swrm_div.sv
`timescale 1ns / 1ps
// restoring divider: 96-bit dividend {t2,t1,t0}, 12-bit divisor, one bit per cycle
module swrm_div
   import swrm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic [WinW:0]      divisor,
   output div_sts_type        sts,
   output logic [SumW-1:0]    quotient
);
   localparam int DivN = SumW + SampW;
   localparam int CntW = $clog2(DivN + 1);

   logic [DivN-1:0] num_ff, num_in;
   logic [WinW+1:0] rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [WinW+1:0] trial;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[WinW:0], num_ff[DivN-1]};
      if (ctl.start) begin
         num_in = ctl.dividend_hi;
         rem_in = '0;
         cnt_in = CntW'(DivN);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DivN-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            num_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = num_ff[SumW-1:0];
endmodule

FILE: src/sliding_window_rate_meter_unit.sv
`timescale 1ns / 1ps
// channel   | dir | signals
// req       | in  | valid/ready, opcode, count, now_ms, window_ms
// rsp       | out | valid/ready, rate_valid, rate_value, set_accepted
// csr       | in  | apb write/read, max_window_ms at 0x0, rate_scale at 0x4
// one item at a time; req_ready is high only in idle, entered the cycle after each rsp transfer
// rsp_valid rises after the req transfer in: a clear goes straight to output, a set is checked
// first, a query waits on the bit-serial divider; an invalid query ends sooner
// add, query and accepted set pass a read and a check state per retired bucket; an add on a
// full ring passes one more check state; no clearing pass, ring entries are read only when live
// synchronous reset; rsp waits in its register while rsp_ready is low
module sliding_window_rate_meter_unit
   import swrm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   swrm_req_if.sink          req,
   swrm_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [AddrW+1:0]  csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   state_type st_ff, st_in;
   logic [WinW-1:0] maxw_ff, maxw_in;
   logic [ScaleW-1:0] scale_ff, scale_in;
   logic [IdxW-1:0] head_ff, head_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic [SumW-1:0] wsum_ff, wsum_in;
   logic [SampW-1:0] wsamp_ff, wsamp_in;
   logic ovf_ff, ovf_in, seen_ff, seen_in;
   logic [TimeW-1:0] start_ff, start_in;
   logic [WinW-1:0] wlen_ff, wlen_in;
   op_type op_ff, op_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [TimeW-1:0] now_ff, now_in;
   logic [WinW-1:0] reqw_ff, reqw_in;
   logic [MemW-1:0] ent_ff, ent_in;
   logic [IdxW-1:0] eidx_ff, eidx_in;
   logic [WinW:0] act_ff, act_in;
   logic [95:0] numr_ff, numr_in;
   logic rvalid_ff, rvalid_in, sacc_ff, sacc_in;
   logic [62:0] rval_ff, rval_in;
   logic [IdxW-1:0] raddr;
   logic we;
   logic [MemW-1:0] rdata;
   logic [IdxW-1:0] newest;
   logic [TimeW-1:0] btime;
   logic [SumW-1:0] bsum;
   logic [SampW-1:0] bsamp;
   logic [TimeW:0] nowd;
   logic [SumW:0] acc;
   logic [SumW-1:0] quot;
   div_ctl_type dctl;
   div_sts_type dsts;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      unique case (csr_paddr[AddrW+1:2])
         RegMaxWin: csr_prdata = {21'd0, maxw_ff};
         RegScale: csr_prdata = {16'd0, scale_ff};
      endcase
   end

   assign newest = head_ff + IdxW'(fill_ff - 1'b1);
   assign btime = rdata[MemW-1 -: TimeW];
   assign bsum = rdata[SumW+SampW-1 -: SumW];
   assign bsamp = rdata[SampW-1:0];
   assign nowd = {1'b0, now_ff} - {1'b0, start_ff} + 1'b1;

   swrm_ram #(.Width(MemW), .Depth(MaxBuckets)) u_ram (
      .clock(clock), .we(we), .waddr(eidx_ff), .wdata(ent_in),
      .raddr(raddr), .rdata(rdata)
   );

   swrm_div u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .divisor({act_ff[WinW-1:0], 1'b0}),
      .sts(dsts), .quotient(quot)
   );

   always_comb begin
      st_in = st_ff;
      maxw_in = maxw_ff;
      scale_in = scale_ff;
      head_in = head_ff;
      fill_in = fill_ff;
      wsum_in = wsum_ff;
      wsamp_in = wsamp_ff;
      ovf_in = ovf_ff;
      seen_in = seen_ff;
      start_in = start_ff;
      wlen_in = wlen_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      now_in = now_ff;
      reqw_in = reqw_ff;
      ent_in = ent_ff;
      eidx_in = eidx_ff;
      act_in = act_ff;
      numr_in = numr_ff;
      rvalid_in = rvalid_ff;
      rval_in = rval_ff;
      sacc_in = sacc_ff;
      raddr = head_ff;
      we = 1'b0;
      dctl.start = 1'b0;
      dctl.dividend_hi = numr_ff;
      acc = '0;
      req.ready = 1'b0;
      if (csr_wr) begin
         unique case (csr_paddr[AddrW+1:2])
            RegMaxWin: maxw_in = csr_pwdata[WinW-1:0];
            RegScale: scale_in = csr_pwdata[ScaleW-1:0];
         endcase
      end
      unique case (st_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               op_in = op_type'(req.opcode);
               cnt_in = req.count;
               now_in = req.now_ms;
               reqw_in = req.window_ms;
               rvalid_in = 1'b0;
               rval_in = '0;
               sacc_in = 1'b0;
               unique case (op_type'(req.opcode))
                  OP_CLEAR: begin
                     head_in = '0;
                     fill_in = '0;
                     wsum_in = '0;
                     wsamp_in = '0;
                     ovf_in = 1'b0;
                     seen_in = 1'b0;
                     start_in = '0;
                     wlen_in = maxw_ff;
                     st_in = ST_OUT;
                  end
                  OP_SETWIN: st_in = ST_SETWIN;
                  default: st_in = ST_DROP_RD;
               endcase
            end
         end
         ST_SETWIN: begin
            if (reqw_ff == '0 || reqw_ff > maxw_ff) begin
               st_in = ST_OUT;
            end else begin
               sacc_in = 1'b1;
               if (seen_ff && $signed({1'b0, now_ff} - {1'b0, TimeW'(reqw_ff)} + 1'b1)
                     > $signed({1'b0, start_ff}))
                  start_in = now_ff - TimeW'(reqw_ff) + 1'b1;
               wlen_in = reqw_ff;
               st_in = ST_DROP_RD;
            end
         end
         ST_DROP_RD: begin
            raddr = head_ff;
            st_in = ST_DROP_CHK;
         end
         ST_DROP_CHK: begin
            if (fill_ff != '0 && $signed({1'b0, btime}) <
                  $signed({1'b0, now_ff} - {1'b0, TimeW'(wlen_ff)} + 1'b1)) begin
               wsum_in = (wsum_ff > bsum) ? wsum_ff - bsum : '0;
               wsamp_in = (wsamp_ff > bsamp) ? wsamp_ff - bsamp : '0;
               head_in = head_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
               st_in = ST_DROP_RD;
            end else begin
               unique case (op_ff)
                  OP_ADD: st_in = ST_ADD_START;
                  OP_QUERY: st_in = ST_Q_PREP;
                  default: st_in = ST_OUT;
               endcase
            end
         end
         ST_ADD_START: begin
            if (!seen_ff || wsamp_ff == '0) begin
               start_in = now_ff;
               seen_in = 1'b1;
            end
            raddr = newest;
            st_in = ST_ADD_NEW_RD;
         end
         ST_ADD_NEW_RD: begin
            if (fill_ff == '0 || now_ff > btime) begin
               if (fill_ff == FillW'(MaxBuckets)) begin
                  raddr = head_ff;
                  st_in = ST_ADD_NEW_CHK;
               end else begin
                  fill_in = fill_ff + 1'b1;
                  eidx_in = head_ff + IdxW'(fill_ff);
                  ent_in = {now_ff, {SumW{1'b0}}, {SampW{1'b0}}};
                  st_in = ST_ADD_WR;
               end
            end else begin
               eidx_in = newest;
               ent_in = rdata;
               st_in = ST_ADD_WR;
            end
         end
         ST_ADD_NEW_CHK: begin
            wsum_in = (wsum_ff > bsum) ? wsum_ff - bsum : '0;
            wsamp_in = (wsamp_ff > bsamp) ? wsamp_ff - bsamp : '0;
            head_in = head_ff + 1'b1;
            eidx_in = head_ff;
            ent_in = {now_ff, {SumW{1'b0}}, {SampW{1'b0}}};
            st_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            we = 1'b1;
            acc = {1'b0, ent_ff[SumW+SampW-1 -: SumW]} + {33'd0, cnt_ff};
            ent_in[SumW+SampW-1 -: SumW] = acc[SumW] ? '1 : acc[SumW-1:0];
            if (ent_ff[SampW-1:0] != '1)
               ent_in[SampW-1:0] = ent_ff[SampW-1:0] + 1'b1;
            if (64'h7FFF_FFFF_FFFF_FFFF - wsum_ff > {32'd0, cnt_ff})
               wsum_in = wsum_ff + {32'd0, cnt_ff};
            else
               ovf_in = 1'b1;
            if (wsamp_ff != '1)
               wsamp_in = wsamp_ff + 1'b1;
            st_in = ST_OUT;
         end
         ST_Q_PREP: begin
            act_in = '0;
            if (seen_ff) begin
               if ({1'b0, start_ff} + {1'b0, TimeW'(wlen_ff)} <= {1'b0, now_ff})
                  act_in = {1'b0, wlen_ff};
               else if (!nowd[TimeW] && nowd != '0)
                  act_in = nowd[WinW:0];
            end
            st_in = ST_Q_MUL;
         end
         ST_Q_MUL: begin
            if (wsamp_ff == '0 || act_ff <= 12'd1 ||
                  (wsamp_ff <= 32'd1 && act_ff < {1'b0, wlen_ff}) || ovf_ff) begin
               st_in = ST_OUT;
            end else begin
               numr_in = {({16'd0, wsum_ff} * {64'd0, scale_ff}), 1'b0}
                  + {84'd0, act_ff};
               st_in = ST_Q_DIV;
            end
         end
         ST_Q_DIV: begin
            if (numr_ff[95:64] >= {19'd0, act_ff, 1'b0}) begin
               st_in = ST_OUT;
            end else begin
               dctl.start = 1'b1;
               st_in = ST_Q_DONE;
            end
         end
         ST_Q_DONE: begin
            if (dsts.done) begin
               if (quot[63] == 1'b0) begin
                  rvalid_in = 1'b1;
                  rval_in = quot[62:0];
               end
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp.valid = (st_ff == ST_OUT);
   assign rsp.rate_valid = rvalid_ff;
   assign rsp.rate_value = rval_ff;
   assign rsp.set_accepted = sacc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         maxw_ff <= 11'd1000;
         scale_ff <= 16'd8000;
         head_ff <= '0;
         fill_ff <= '0;
         wsum_ff <= '0;
         wsamp_ff <= '0;
         ovf_ff <= 1'b0;
         seen_ff <= 1'b0;
         start_ff <= '0;
         wlen_ff <= 11'd1000;
      end else begin
         st_ff <= st_in;
         maxw_ff <= maxw_in;
         scale_ff <= scale_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
         wsum_ff <= wsum_in;
         wsamp_ff <= wsamp_in;
         ovf_ff <= ovf_in;
         seen_ff <= seen_in;
         start_ff <= start_in;
         wlen_ff <= wlen_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      now_ff <= now_in;
      reqw_ff <= reqw_in;
      ent_ff <= ent_in;
      eidx_ff <= eidx_in;
      act_ff <= act_in;
      numr_ff <= numr_in;
      rvalid_ff <= rvalid_in;
      rval_ff <= rval_in;
      sacc_ff <= sacc_in;
   end

   logic unused_ok;
   assign unused_ok = dsts.busy;
endmodule

FILE: src/swrm_checker.sv
`timescale 1ns / 1ps
`include "sliding_window_rate_meter_unit_assert.svh"
module swrm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rate_valid,
   input logic [62:0] rate_value,
   input logic        set_accepted
);
   `SWRM_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `SWRM_ASSERT_IMP(a_zero_rate, clock, reset, rsp_valid && !rate_valid, rate_value == '0)
   `SWRM_ASSERT_IMP(a_one_kind, clock, reset, rsp_valid, !(rate_valid && set_accepted))
   `SWRM_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind sliding_window_rate_meter_unit swrm_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rate_valid(rsp.rate_valid), .rate_value(rsp.rate_value),
   .set_accepted(rsp.set_accepted)
);
